/* hw/rtl/spectrum_reorder_requantizer_unit_macros.svh */
// Assertion helpers for the spectrum reorder requantizer
`ifndef SPECTRUM_REORDER_REQUANTIZER_UNIT_MACROS_SVH
`define SPECTRUM_REORDER_REQUANTIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SRRQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define SRRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hw/rtl/srrq_pkg.sv */
`default_nettype none

package srrq_pkg;

   // Defaults for the top-level parameters
   localparam int CHANNELS_DEF       = 256;
   localparam int WARMUP_SPECTRA_DEF = 10;

   // Fixed field widths
   localparam int MAG_W      = 15;
   localparam int VALUE_W    = 16;
   localparam int CHAN_OUT_W = 8;
   localparam int BYTE_W     = 8;
   localparam int MID_LEVEL  = 128;
   localparam int BYTE_MAX   = 255;

   // Input function codes
   localparam logic FUNC_RAW   = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Output mode codes
   localparam logic MODE_WORD = 1'b0;
   localparam logic MODE_BYTE = 1'b1;

   // Register index of output_mode (paddr bit 2)
   localparam logic CSR_IDX_MODE = 1'b0;

   typedef struct packed {
      logic                func;
      logic [VALUE_W-1:0]  raw_word;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0]    out_value;
      logic [CHAN_OUT_W-1:0] out_channel;
      logic                  end_of_spectrum;
   } rsp_payload_type;

   // Per-channel tag travelling alongside a frame store read
   typedef struct packed {
      logic                  force_zero;
      logic                  last;
      logic [CHAN_OUT_W-1:0] chan;
   } emit_tag_type;

endpackage

`default_nettype wire

/* hw/rtl/srrq_ram.sv */
`default_nettype none

module srrq_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/srrq_mean_div.sv */
`default_nettype none

module srrq_mean_div #(
   parameter int CHANNELS       = 256,
   parameter int WARMUP_SPECTRA = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [$clog2(longint'(WARMUP_SPECTRA) * longint'(CHANNELS) * 32767 + 1)-1:0]
                     dividend,
   output logic      busy,
   output logic [srrq_pkg::MAG_W-1:0] quotient
);

   import srrq_pkg::*;

   localparam longint NPROD  = longint'(WARMUP_SPECTRA) * longint'(CHANNELS);
   localparam int     SUM_W  = $clog2(NPROD * 32767 + 1);
   localparam int     SHIFT  = SUM_W + $clog2(NPROD);
   localparam int     PROD_W = 2 * SUM_W + 1;
   // Reciprocal rounded up; exact floor quotient for every SUM_W-bit dividend
   localparam longint RECIP  = ((longint'(1) << SHIFT) + NPROD - 1) / NPROD;

   logic [SUM_W-1:0]  num_ff, num_in;
   logic [PROD_W-1:0] prod;
   logic [MAG_W-1:0]  q_ff, q_in;
   logic              busy_ff, busy_in;

   // Capture the sum, then one multiply by the reciprocal of the sample count
   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      busy_in = 1'b0;
      prod    = PROD_W'(num_ff) * PROD_W'(RECIP);
      if (start) begin
         num_in  = dividend;
         busy_in = 1'b1;
      end
      if (busy_ff) begin
         q_in = MAG_W'(prod >> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

/* hw/rtl/srrq_out_stage.sv */
`default_nettype none

module srrq_out_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire srrq_pkg::emit_tag_type        load_tag,
   input  wire logic [srrq_pkg::MAG_W-1:0]    rd_mag,
   input  wire logic                          output_mode,
   input  wire logic [srrq_pkg::MAG_W-1:0]    mean,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output srrq_pkg::rsp_payload_type          rsp_payload,
   output logic                               accept_room
);

   import srrq_pkg::*;

   localparam int K_W = MAG_W + 2;

   emit_tag_type    s1_tag_ff;
   logic            s1_valid_ff, s1_valid_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            out_free;
   logic            s1_move;
   logic signed [K_W-1:0] level;
   logic [VALUE_W-1:0]    value;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign s1_move     = s1_valid_ff && out_free;
   assign accept_room = !s1_valid_ff || out_free;

   // Requantise the sample held in the read register
   always_comb begin
      level = K_W'(signed'(MID_LEVEL)) - signed'({2'b00, rd_mag})
              + signed'({2'b00, mean});
      if (s1_tag_ff.force_zero) begin
         value = '0;
      end else if (output_mode == MODE_WORD) begin
         value = VALUE_W'(0) - {1'b0, rd_mag};
      end else if (level < 0) begin
         value = '0;
      end else if (level > K_W'(signed'(BYTE_MAX))) begin
         value = VALUE_W'(BYTE_MAX);
      end else begin
         value = {{(VALUE_W-BYTE_W){1'b0}}, level[BYTE_W-1:0]};
      end
   end

   // Read stage and result register occupancy
   always_comb begin
      s1_valid_in  = load || (s1_valid_ff && !out_free);
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);
      out_in       = out_ff;
      if (s1_move) begin
         out_in.out_value       = value;
         out_in.out_channel     = s1_tag_ff.chan;
         out_in.end_of_spectrum = s1_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         s1_tag_ff <= load_tag;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

/* hw/rtl/spectrum_reorder_requantizer_unit.sv */
`default_nettype none

// Spectrum reorder requantiser. Raw words arrive one transaction per cycle;
// each becomes a 15-bit sample magnitude written in reversed channel order
// into one bank of a two-bank frame store (one synchronous RAM), while the
// other bank is read out one channel per accepted transaction (raw or
// drain). Results pass through the read register and then the result
// register, and the block keeps one transaction per cycle as long as the
// result side takes them. The first WARMUP_SPECTRA spectra give no
// results; once warm-up ends their sum is multiplied by the reciprocal of
// the sample count to form the mean, and input is held off while that
// happens (start and multiply). Output channels 0, 1, CHANNELS-2 and
// CHANNELS-1 always read zero. output_mode sits at byte address 0.
module spectrum_reorder_requantizer_unit #(
   parameter int CHANNELS       = srrq_pkg::CHANNELS_DEF,
   parameter int WARMUP_SPECTRA = srrq_pkg::WARMUP_SPECTRA_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire srrq_pkg::req_payload_type   req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output srrq_pkg::rsp_payload_type        rsp_payload,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [2:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   import srrq_pkg::*;

   localparam int     CH_W   = $clog2(CHANNELS);
   localparam int     DEPTH  = 2 << CH_W;
   localparam int     SEEN_W = $clog2(WARMUP_SPECTRA + 2);
   localparam longint NPROD  = longint'(WARMUP_SPECTRA) * longint'(CHANNELS);
   localparam int     SUM_W  = $clog2(NPROD * 32767 + 1);

   logic [CH_W-1:0]   wpos_ff, wpos_in;
   logic [CH_W-1:0]   rpos_ff, rpos_in;
   logic              bank_ff, bank_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              pending_ff, pending_in;
   logic              mode_ff, mode_in;
   logic              div_start_ff, div_start_in;

   logic              accept;
   logic              emit;
   logic              do_write;
   logic [MAG_W-1:0]  wr_mag;
   logic [CH_W-1:0]   wr_chan;
   logic [CH_W+7:0]   rpos_wide;
   emit_tag_type      tag;
   logic [MAG_W-1:0]  rd_mag;
   logic [MAG_W-1:0]  mean;
   logic              div_busy;
   logic              room;
   logic              csr_wr;

   assign accept    = req_valid && req_ready;
   assign emit      = accept && pending_ff;
   assign do_write  = accept && (req_payload.func == FUNC_RAW);
   assign wr_mag    = ~req_payload.raw_word[MAG_W-1:0];
   assign wr_chan   = CH_W'(CHANNELS - 1) - wpos_ff;
   assign req_ready = room && !div_busy && !div_start_ff;

   // Tag for the channel being read out
   always_comb begin
      rpos_wide      = {8'b0, rpos_ff};
      tag.chan       = rpos_wide[CHAN_OUT_W-1:0];
      tag.last       = (rpos_ff == CH_W'(CHANNELS - 1));
      tag.force_zero = (rpos_ff < CH_W'(2)) || (rpos_ff >= CH_W'(CHANNELS - 2));
   end

   // Write and read sequencing across the two banks
   always_comb begin
      wpos_in      = wpos_ff;
      rpos_in      = rpos_ff;
      bank_in      = bank_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      pending_in   = pending_ff;
      div_start_in = 1'b0;
      if (emit) begin
         if (rpos_ff == CH_W'(CHANNELS - 1)) begin
            rpos_in    = '0;
            pending_in = 1'b0;
         end else begin
            rpos_in = rpos_ff + CH_W'(1);
         end
      end
      if (do_write) begin
         if (seen_ff < SEEN_W'(WARMUP_SPECTRA)) begin
            sum_in = sum_ff + SUM_W'(wr_mag);
         end
         if (wpos_ff == CH_W'(CHANNELS - 1)) begin
            wpos_in = '0;
            bank_in = !bank_ff;
            if (seen_ff <= SEEN_W'(WARMUP_SPECTRA)) begin
               seen_in = seen_ff + SEEN_W'(1);
            end
            if (seen_ff == SEEN_W'(WARMUP_SPECTRA - 1)) begin
               div_start_in = 1'b1;
            end
            if (seen_in > SEEN_W'(WARMUP_SPECTRA)) begin
               pending_in = 1'b1;
               rpos_in    = '0;
            end
         end else begin
            wpos_in = wpos_ff + CH_W'(1);
         end
      end
   end

   // Configuration register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MODE) ? {31'b0, mode_ff} : 32'b0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_MODE)) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         bank_ff      <= 1'b0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         pending_ff   <= 1'b0;
         mode_ff      <= MODE_WORD;
         div_start_ff <= 1'b0;
      end else begin
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         bank_ff      <= bank_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         pending_ff   <= pending_in;
         mode_ff      <= mode_in;
         div_start_ff <= div_start_in;
      end
   end

   // Frame store: writes go to the filling bank, reads to the other one
   srrq_ram #(
      .WIDTH (MAG_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr ({bank_ff, wr_chan}),
      .wr_data (wr_mag),
      .rd_en   (emit),
      .rd_addr ({!bank_ff, rpos_ff}),
      .rd_data (rd_mag)
   );

   // Mean of the warm-up samples
   srrq_mean_div #(
      .CHANNELS       (CHANNELS),
      .WARMUP_SPECTRA (WARMUP_SPECTRA)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .busy     (div_busy),
      .quotient (mean)
   );

   // Requantiser and result register
   srrq_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (emit),
      .load_tag    (tag),
      .rd_mag      (rd_mag),
      .output_mode (mode_ff),
      .mean        (mean),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .accept_room (room)
   );

`include "spectrum_reorder_requantizer_unit_macros.svh"

   // Read-out only runs once warm-up and one further spectrum are done
   `SRRQ_ASSERT_NOW(a_pending_after_warmup, clock, reset, pending_ff, seen_ff == SEEN_W'(WARMUP_SPECTRA + 1))
   // The mean is settled before any channel is read out
   `SRRQ_ASSERT_NOW(a_mean_ready, clock, reset, pending_ff, !div_busy && !div_start_ff)
   // Reading the last channel of a spectrum ends the read-out
   `SRRQ_ASSERT_NEXT(a_last_ends, clock, reset, emit && tag.last && !do_write, !pending_ff)

endmodule

`default_nettype wire
